// ===== rtl/aec_pkg.sv =====
package aec_pkg;

  // Store geometry: one smoothed value for each buffer position.
  localparam int unsigned BufferDepth = 1024;
  localparam int unsigned IdxW        = $clog2(BufferDepth);
  localparam int unsigned OnsetLag    = 40;

  // Field widths of the stream payloads.
  localparam int unsigned SampleW   = 16;
  localparam int unsigned PosW      = 10;
  localparam int unsigned CountW    = 11;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 16;

  // Bit offsets inside the request tdata.
  localparam int unsigned SampleLsb = 0;
  localparam int unsigned PosLsb    = SampleLsb + SampleW;
  localparam int unsigned CountLsb  = PosLsb + PosW;

  // Bit offsets inside the result tdata.
  localparam int unsigned BassLsb   = ValueW;
  localparam int unsigned PeakLsb   = ValueW + 1;
  localparam int unsigned OnsetLsb  = ValueW + 2;

  // Register reset values.
  localparam logic [14:0]        KeepReset  = 15'd29491;
  localparam logic [14:0]        NewReset   = 15'd3277;
  localparam logic signed [15:0] PeakReset  = 16'sd328;
  localparam logic [15:0]        RatioReset = 16'd6554;
  localparam logic [14:0]        RiseReset  = 15'd3277;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic [ModeW-1:0] {
    MODE_SAMPLE     = 2'd0,
    MODE_READ_BASS  = 2'd1,
    MODE_READ_PEAK  = 2'd2,
    MODE_READ_ONSET = 2'd3
  } mode_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_SMOOTH_KEEP = 3'd0,
    REG_SMOOTH_NEW  = 3'd1,
    REG_PEAK_LEVEL  = 3'd2,
    REG_ONSET_RATIO = 3'd3,
    REG_BASS_RISE   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [14:0]        smooth_keep;
    logic [14:0]        smooth_new;
    logic signed [15:0] peak_level;
    logic [15:0]        onset_ratio;
    logic [14:0]        bass_rise;
  } cfg_t;

  typedef struct packed {
    logic               rd_en;
    idx_t               rd_addr_a;
    idx_t               rd_addr_b;
    logic               wr_en;
    idx_t               wr_addr;
    logic signed [15:0] wr_data;
  } mem_req_t;

endpackage

// ===== rtl/aec_cfg_regs.sv =====
module aec_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aec_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [aec_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output aec_pkg::cfg_t                 cfg_o
);

  aec_pkg::cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register file; unknown indices are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.smooth_keep <= aec_pkg::KeepReset;
      cfg_q.smooth_new  <= aec_pkg::NewReset;
      cfg_q.peak_level  <= aec_pkg::PeakReset;
      cfg_q.onset_ratio <= aec_pkg::RatioReset;
      cfg_q.bass_rise   <= aec_pkg::RiseReset;
    end else if (cfg_valid_i) begin
      unique case (aec_pkg::cfg_reg_e'(cfg_addr_i))
        aec_pkg::REG_SMOOTH_KEEP: cfg_q.smooth_keep <= cfg_wdata_i[14:0];
        aec_pkg::REG_SMOOTH_NEW:  cfg_q.smooth_new  <= cfg_wdata_i[14:0];
        aec_pkg::REG_PEAK_LEVEL:  cfg_q.peak_level  <= cfg_wdata_i;
        aec_pkg::REG_ONSET_RATIO: cfg_q.onset_ratio <= cfg_wdata_i;
        aec_pkg::REG_BASS_RISE:   cfg_q.bass_rise   <= cfg_wdata_i[14:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/aec_store.sv =====
module aec_store (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  aec_pkg::mem_req_t        req_i,
  output logic signed [15:0]       rd_data_a_o,
  output logic signed [15:0]       rd_data_b_o,
  output logic                     busy_o
);

  logic signed [15:0] mem_q [aec_pkg::BufferDepth];
  logic signed [15:0] rd_a_q;
  logic signed [15:0] rd_b_q;
  logic               clr_busy_q;
  aec_pkg::idx_t      clr_addr_q;

  logic               wr_en;
  aec_pkg::idx_t      wr_addr;
  logic signed [15:0] wr_data;

  // Clearing pass after reset: one entry per cycle from the bottom up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == aec_pkg::idx_t'(aec_pkg::BufferDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // The sweep owns the write port while it runs.
  always_comb begin
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
      wr_data = '0;
    end else begin
      wr_en   = req_i.wr_en;
      wr_addr = req_i.wr_addr;
      wr_data = req_i.wr_data;
    end
  end

  // One write port, two registered read ports; reads return the old contents.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_a_q <= mem_q[req_i.rd_addr_a];
      rd_b_q <= mem_q[req_i.rd_addr_b];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign busy_o      = clr_busy_q;

endmodule

// ===== rtl/aec_pipe.sv =====
module aec_pipe #(
  parameter int unsigned ONSET_LAG = aec_pkg::OnsetLag
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aec_pkg::cfg_t                 cfg_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [aec_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic [aec_pkg::ModeW-1:0]     s_axis_tuser,
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [aec_pkg::OutDataW-1:0]  m_axis_tdata,
  // Store access
  output aec_pkg::mem_req_t             mem_req_o,
  input  logic signed [15:0]            rd_old_i,
  input  logic signed [15:0]            rd_lag_i,
  input  logic                          store_busy_i
);

  localparam aec_pkg::idx_t LagIdx = ONSET_LAG[aec_pkg::IdxW-1:0];

  // Request decode
  aec_pkg::mode_e                 in_mode;
  logic signed [15:0]             in_sample;
  logic [aec_pkg::PosW-1:0]       in_pos;
  logic [aec_pkg::CountW-1:0]     in_count;
  aec_pkg::idx_t                  in_idx;
  logic                           in_is_sample;
  logic                           hazard;
  logic                           adv;
  logic                           accept;

  // Stage 1: store read data present
  logic                           s1_valid_q;
  aec_pkg::mode_e                 s1_mode_q;
  logic signed [15:0]             s1_sample_q;
  logic signed [15:0]             s1_first_q;
  aec_pkg::idx_t                  s1_idx_q;
  aec_pkg::idx_t                  s1_lag_addr_q;
  logic                           s1_pair_q;
  logic                           s1_lag_ok_q;
  logic signed [15:0]             pair_first_q;
  logic signed [15:0]             smooth_old;
  logic signed [31:0]             keep_prod;
  logic signed [31:0]             new_prod;
  logic signed [31:0]             sq_first;
  logic signed [31:0]             sq_sample;

  // Stage 2: accumulate, round, saturate
  logic                           s2_valid_q;
  aec_pkg::mode_e                 s2_mode_q;
  aec_pkg::idx_t                  s2_idx_q;
  aec_pkg::idx_t                  s2_lag_addr_q;
  logic                           s2_pair_q;
  logic                           s2_lag_ok_q;
  logic signed [15:0]             s2_lag_raw_q;
  logic signed [31:0]             s2_keep_prod_q;
  logic signed [31:0]             s2_new_prod_q;
  logic [30:0]                    s2_sq_a_q;
  logic [30:0]                    s2_sq_b_q;
  logic signed [32:0]             acc;
  logic signed [17:0]             q_wide;
  logic signed [15:0]             q_sat;
  logic signed [15:0]             lag_val;
  logic signed [32:0]             onset_prod;
  logic [31:0]                    energy;
  logic [31:0]                    bass_thr;
  logic                           bass_hit;
  logic [30:0]                    last_avg_q;
  logic                           wr_en;

  // Write-back records for forwarding to reads that missed them
  logic                           wb1_valid_q;
  aec_pkg::idx_t                  wb1_addr_q;
  logic signed [15:0]             wb1_data_q;
  logic                           wb2_valid_q;
  aec_pkg::idx_t                  wb2_addr_q;
  logic signed [15:0]             wb2_data_q;

  // Stage 3: event tests and counters
  logic                           s3_valid_q;
  aec_pkg::mode_e                 s3_mode_q;
  logic signed [15:0]             s3_q_q;
  logic signed [32:0]             s3_onset_prod_q;
  logic                           s3_lag_ok_q;
  logic                           s3_bass_q;
  logic signed [15:0]             peak_level;
  logic signed [33:0]             q_scaled;
  logic signed [33:0]             onset_ext;
  logic                           peak_hit;
  logic                           onset_hit;
  logic [aec_pkg::ValueW-1:0]     bass_cnt_q;
  logic [aec_pkg::ValueW-1:0]     peak_cnt_q;
  logic [aec_pkg::ValueW-1:0]     onset_cnt_q;
  logic [aec_pkg::ValueW-1:0]     read_value;

  // Output register
  logic                           out_valid_q;
  logic [aec_pkg::ValueW-1:0]     out_value_q;
  logic                           out_bass_q;
  logic                           out_peak_q;
  logic                           out_onset_q;

  // Unpack the request.
  assign in_mode      = aec_pkg::mode_e'(s_axis_tuser);
  assign in_sample    = s_axis_tdata[aec_pkg::SampleLsb +: aec_pkg::SampleW];
  assign in_pos       = s_axis_tdata[aec_pkg::PosLsb +: aec_pkg::PosW];
  assign in_count     = s_axis_tdata[aec_pkg::CountLsb +: aec_pkg::CountW];
  assign in_idx       = in_pos[aec_pkg::IdxW-1:0];
  assign in_is_sample = (in_mode == aec_pkg::MODE_SAMPLE);

  // The whole pipeline moves when the output register can take a result.
  // A sample for the position still in stage 1 is held until that one moves
  // on, so that its old value is caught from the write-back record instead.
  assign adv    = !out_valid_q || m_axis_tready;
  assign hazard = s1_valid_q && (s1_mode_q == aec_pkg::MODE_SAMPLE) && in_is_sample &&
                  (s1_idx_q == in_idx);
  assign s_axis_tready = adv && !store_busy_i && !hazard;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Store port requests.
  assign wr_en = adv && s2_valid_q && (s2_mode_q == aec_pkg::MODE_SAMPLE);
  always_comb begin
    mem_req_o.rd_en     = accept;
    mem_req_o.rd_addr_a = in_idx;
    mem_req_o.rd_addr_b = in_idx - LagIdx;
    mem_req_o.wr_en     = wr_en;
    mem_req_o.wr_addr   = s2_idx_q;
    mem_req_o.wr_data   = q_sat;
  end

  // Stage 1 products; the old value comes from the write made at the read edge
  // when the addresses agree.
  assign smooth_old = (wb1_valid_q && (wb1_addr_q == s1_idx_q)) ? wb1_data_q : rd_old_i;
  assign keep_prod  = $signed({1'b0, cfg_i.smooth_keep}) * smooth_old;
  assign new_prod   = $signed({1'b0, cfg_i.smooth_new}) * s1_sample_q;
  assign sq_first   = s1_first_q * s1_first_q;
  assign sq_sample  = s1_sample_q * s1_sample_q;

  // Stage 2: round to Q15 with floor after adding half, then saturate.
  assign acc    = $signed({s2_keep_prod_q[31], s2_keep_prod_q}) +
                  $signed({s2_new_prod_q[31], s2_new_prod_q}) + 33'sd16384;
  assign q_wide = acc[32:15];
  always_comb begin
    if (q_wide > 18'sd32767) begin
      q_sat = 16'sh7FFF;
    end else if (q_wide < -18'sd32768) begin
      q_sat = -16'sh8000;
    end else begin
      q_sat = q_wide[15:0];
    end
  end

  // Lagged value: the two most recent writes may be newer than the read.
  always_comb begin
    if (wb1_valid_q && (wb1_addr_q == s2_lag_addr_q)) begin
      lag_val = wb1_data_q;
    end else if (wb2_valid_q && (wb2_addr_q == s2_lag_addr_q)) begin
      lag_val = wb2_data_q;
    end else begin
      lag_val = s2_lag_raw_q;
    end
  end
  assign onset_prod = $signed({1'b0, cfg_i.onset_ratio}) * lag_val;

  // Pair energy against the rise plus the previous pair's average.
  assign energy   = {1'b0, s2_sq_a_q} + {1'b0, s2_sq_b_q};
  assign bass_thr = {1'b0, cfg_i.bass_rise, 16'b0} + {1'b0, last_avg_q};
  assign bass_hit = s2_pair_q && (energy > bass_thr);

  // Stage 3 event tests.
  assign peak_level = cfg_i.peak_level;
  assign q_scaled   = {{3{s3_q_q[15]}}, s3_q_q, 15'b0};
  assign onset_ext  = {s3_onset_prod_q[32], s3_onset_prod_q};
  assign peak_hit   = (s3_mode_q == aec_pkg::MODE_SAMPLE) && (s3_q_q > peak_level);
  assign onset_hit  = (s3_mode_q == aec_pkg::MODE_SAMPLE) && s3_lag_ok_q &&
                      (q_scaled > onset_ext);

  always_comb begin
    unique case (s3_mode_q)
      aec_pkg::MODE_READ_BASS:  read_value = bass_cnt_q;
      aec_pkg::MODE_READ_PEAK:  read_value = peak_cnt_q;
      aec_pkg::MODE_READ_ONSET: read_value = onset_cnt_q;
      default:                  read_value = '0;
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      wb1_valid_q  <= 1'b0;
      wb2_valid_q  <= 1'b0;
      pair_first_q <= '0;
      last_avg_q   <= '0;
      bass_cnt_q   <= '0;
      peak_cnt_q   <= '0;
      onset_cnt_q  <= '0;
    end else if (adv) begin
      s1_valid_q  <= accept;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
      wb1_valid_q <= wr_en;
      wb2_valid_q <= wb1_valid_q;
      if (accept && in_is_sample && !in_pos[0]) begin
        pair_first_q <= in_sample;
      end
      if (s2_valid_q && s2_pair_q) begin
        last_avg_q <= energy[31:1];
      end
      if (s3_valid_q) begin
        unique case (s3_mode_q)
          aec_pkg::MODE_READ_BASS:  bass_cnt_q  <= '0;
          aec_pkg::MODE_READ_PEAK:  peak_cnt_q  <= '0;
          aec_pkg::MODE_READ_ONSET: onset_cnt_q <= '0;
          default: begin
            if (s3_bass_q && (bass_cnt_q != '1)) begin
              bass_cnt_q <= bass_cnt_q + 1'b1;
            end
            if (peak_hit && (peak_cnt_q != '1)) begin
              peak_cnt_q <= peak_cnt_q + 1'b1;
            end
            if (onset_hit && (onset_cnt_q != '1)) begin
              onset_cnt_q <= onset_cnt_q + 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (accept) begin
        s1_mode_q     <= in_mode;
        s1_sample_q   <= in_sample;
        s1_first_q    <= pair_first_q;
        s1_idx_q      <= in_idx;
        s1_lag_addr_q <= in_idx - LagIdx;
        s1_pair_q     <= in_is_sample && in_pos[0] &&
                         (({1'b0, in_pos} + 11'd1) < in_count);
        s1_lag_ok_q   <= in_is_sample && (in_idx >= LagIdx);
      end
      s2_mode_q       <= s1_mode_q;
      s2_idx_q        <= s1_idx_q;
      s2_lag_addr_q   <= s1_lag_addr_q;
      s2_pair_q       <= s1_pair_q;
      s2_lag_ok_q     <= s1_lag_ok_q;
      s2_lag_raw_q    <= rd_lag_i;
      s2_keep_prod_q  <= keep_prod;
      s2_new_prod_q   <= new_prod;
      s2_sq_a_q       <= sq_first[30:0];
      s2_sq_b_q       <= sq_sample[30:0];
      wb1_addr_q      <= s2_idx_q;
      wb1_data_q      <= q_sat;
      wb2_addr_q      <= wb1_addr_q;
      wb2_data_q      <= wb1_data_q;
      s3_mode_q       <= s2_mode_q;
      s3_q_q          <= q_sat;
      s3_onset_prod_q <= onset_prod;
      s3_lag_ok_q     <= s2_lag_ok_q;
      s3_bass_q       <= bass_hit;
      out_value_q     <= read_value;
      out_bass_q      <= (s3_mode_q == aec_pkg::MODE_SAMPLE) && s3_bass_q;
      out_peak_q      <= peak_hit;
      out_onset_q     <= onset_hit;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(aec_pkg::OutDataW - aec_pkg::ValueW - 3){1'b0}},
                          out_onset_q, out_peak_q, out_bass_q, out_value_q};

endmodule

// ===== rtl/audio_event_counter.sv =====
// Audio event counter. Each request carries a mode in tuser and, in tdata, a
// signed Q15 sample, its position in the buffer and the buffer length; every
// request gives exactly one result. A sample updates the smoothed value kept
// for its position in a 1024-entry store and may count a peak, an onset
// (against the value ONSET_LAG positions back) and a bass rise (on the odd
// sample of a pair); the three flags come back with a zero value. The three
// read modes return one saturating 32-bit counter and clear it. One request
// is taken per cycle while the output is not stalled and the store is not
// being cleared; its result passes stages 1 to 3 and the output register,
// the four-stage pipeline through which the store is read and written back.
// A sample for the same position as the one still in stage 1 waits for
// that write-back. After reset the store is cleared, one entry per cycle,
// and no request is taken until it is done; configuration writes are taken
// at any time and should be made while the block is idle.
module audio_event_counter #(
  parameter int unsigned ONSET_LAG = aec_pkg::OnsetLag
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [aec_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [aec_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [aec_pkg::InDataW-1:0]   s_axis_tdata,  // sample[15:0], position[25:16],
                                                       // sample_count[36:26]
  input  logic [aec_pkg::ModeW-1:0]     s_axis_tuser,  // mode[1:0]
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [aec_pkg::OutDataW-1:0]  m_axis_tdata   // read_value[31:0], bass_hit[32],
                                                       // peak_hit[33], onset_hit[34]
);

  aec_pkg::cfg_t     cfg;
  aec_pkg::mem_req_t mem_req;
  logic signed [15:0] rd_old;
  logic signed [15:0] rd_lag;
  logic               store_busy;

  aec_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  aec_store u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (mem_req),
    .rd_data_a_o (rd_old),
    .rd_data_b_o (rd_lag),
    .busy_o      (store_busy)
  );

  aec_pipe #(
    .ONSET_LAG (ONSET_LAG)
  ) u_pipe (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_req_o     (mem_req),
    .rd_old_i      (rd_old),
    .rd_lag_i      (rd_lag),
    .store_busy_i  (store_busy)
  );

endmodule
